/* hdl/chgs_pkg.sv */
// shared types and constants for the convex hull unit
`default_nettype none
package chgs_pkg;

   localparam int MaxPoints = 64;
   localparam int CoordBits = 16;
   localparam int IdxBits   = $clog2(MaxPoints);
   localparam int CntBits   = $clog2(MaxPoints + 1);
   localparam int PtBits    = 2 * CoordBits;
   localparam int DiffBits  = CoordBits + 1;
   localparam int ProdBits  = 2 * DiffBits;
   localparam int CrossBits = ProdBits + 1;

   typedef struct packed {
      logic signed [CoordBits-1:0] point_x;
      logic signed [CoordBits-1:0] point_y;
      logic                        set_last;
   } req_word_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] hull_x;
      logic signed [CoordBits-1:0] hull_y;
      logic                        hull_last;
      logic                        dropped_points;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_MIN_RD, ST_MIN_CMP,
      ST_SRT_RDP, ST_SRT_WTP, ST_SRT_CHK,
      ST_SRT_RDO, ST_SRT_WTO, ST_SRT_RDQ, ST_SRT_WTQ, ST_SRT_MUL, ST_SRT_DEC,
      ST_SCN_RDP, ST_SCN_WTP, ST_SCN_CHK,
      ST_SCN_RDB, ST_SCN_WTB, ST_SCN_RDA, ST_SCN_WTA, ST_SCN_MUL, ST_SCN_DEC,
      ST_OUT_RDI, ST_OUT_WTI, ST_OUT_RDP, ST_OUT_WTP
   } state_type;

endpackage : chgs_pkg
`default_nettype wire

/* hdl/chgs_ram.sv */
// generic single port ram with registered read
`default_nettype none
module chgs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule : chgs_ram
`default_nettype wire

/* hdl/convex_hull_graham_scan_unit.sv */
// convex hull unit: point load, start search, angle sort, stack scan, emit
//
// Points arrive on the req_ channel one word per cycle while busy is low; a
// word is taken at a rising edge with start high and busy low. The word with
// set_last high closes the set and raises busy until the whole hull has been
// sent. Points beyond 64 are dropped and flag dropped_points on every result.
// Storage for N stored points is one point memory, one order memory and one
// stack memory, each with one port. The steps in order:
//   start search   reads each point and keeps the lowest
//   insertion sort reads each point and compares it with sorted entries,
//                  up to N*N/2 compares
//   stack scan     reads each sorted point, then turn tests and pops,
//                  at most 2N tests
//   emit           reads each hull vertex from the stack and point memory
// Each hull vertex appears on the rsp_ ports for one cycle with rsp_valid
// high; the receiver cannot stall it. Vertices come counter-clockwise from
// the lowest point and the final one has hull_last set. Synchronous reset
// returns to the load state with an empty set; memory contents are not
// cleared.
`default_nettype none
module convex_hull_graham_scan_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire chgs_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   output chgs_pkg::rsp_word_type     rsp_word
);
   import chgs_pkg::*;

   // memories
   logic               pm_we, om_we, sm_we;
   logic [IdxBits-1:0] pm_addr, om_addr, sm_addr;
   logic [PtBits-1:0]  pm_wdata, pm_rdata;
   logic [IdxBits-1:0] om_wdata, om_rdata, sm_wdata, sm_rdata;

   chgs_ram #(.Width(PtBits), .Depth(MaxPoints)) u_points (
      .clock(clock), .wr_en(pm_we), .addr(pm_addr), .wr_data(pm_wdata),
      .rd_data(pm_rdata));
   chgs_ram #(.Width(IdxBits), .Depth(MaxPoints)) u_order (
      .clock(clock), .wr_en(om_we), .addr(om_addr), .wr_data(om_wdata),
      .rd_data(om_rdata));
   chgs_ram #(.Width(IdxBits), .Depth(MaxPoints)) u_stack (
      .clock(clock), .wr_en(sm_we), .addr(sm_addr), .wr_data(sm_wdata),
      .rd_data(sm_rdata));

   // registers
   state_type state_ff, state_in;
   logic [CntBits-1:0] count_ff, count_in;      // stored points
   logic               ovf_ff, ovf_in, drop_ff, drop_in;
   logic [CntBits-1:0] i_ff, i_in;              // outer index
   logic [CntBits-1:0] n_ff, n_in;              // sorted entries
   logic [CntBits-1:0] k_ff, k_in;              // insert position
   logic [CntBits-1:0] sp_ff, sp_in;            // stack depth
   logic [IdxBits-1:0] sidx_ff, sidx_in;        // start index
   logic signed [CoordBits-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CoordBits-1:0] px_ff, px_in, py_ff, py_in;  // current point
   logic [IdxBits-1:0] pidx_ff, pidx_in;
   logic signed [CoordBits-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [IdxBits-1:0] oidx_ff, oidx_in;        // order entry being moved
   logic signed [ProdBits-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic signed [DiffBits-1:0] ax_ff, ax_in, ay_ff, ay_in, cx_ff, cx_in, cy_ff, cy_in;
   logic               rv_ff, rv_in;
   rsp_word_type       rw_ff, rw_in;

   logic signed [CoordBits-1:0] rx, ry;
   logic signed [CrossBits-1:0] crs;
   logic [DiffBits-1:0] aix, aiy, ajx, ajy;
   logic before_w;

   assign rx  = pm_rdata[PtBits-1:CoordBits];
   assign ry  = pm_rdata[CoordBits-1:0];
   assign crs = CrossBits'(m1_ff) - CrossBits'(m2_ff);
   assign busy = (state_ff != ST_LOAD);
   assign rsp_valid = rv_ff;
   assign rsp_word  = rw_ff;

   // sort order with collinear tie breaks: ax/ay hold point i, cx/cy point j offsets
   always_comb begin
      aix = ax_ff[DiffBits-1] ? DiffBits'(-ax_ff) : DiffBits'(ax_ff);
      aiy = ay_ff[DiffBits-1] ? DiffBits'(-ay_ff) : DiffBits'(ay_ff);
      ajx = cx_ff[DiffBits-1] ? DiffBits'(-cx_ff) : DiffBits'(cx_ff);
      ajy = cy_ff[DiffBits-1] ? DiffBits'(-cy_ff) : DiffBits'(cy_ff);
      if (crs != '0)       before_w = (crs > 0);
      else if (aix != ajx) before_w = (aix < ajx);
      else                 before_w = (aiy < ajy);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      drop_ff <= drop_in; i_ff <= i_in; n_ff <= n_in; k_ff <= k_in;
      sp_ff <= sp_in; sidx_ff <= sidx_in; sx_ff <= sx_in; sy_ff <= sy_in;
      px_ff <= px_in; py_ff <= py_in; pidx_ff <= pidx_in;
      bx_ff <= bx_in; by_ff <= by_in; oidx_ff <= oidx_in;
      m1_ff <= m1_in; m2_ff <= m2_in;
      ax_ff <= ax_in; ay_ff <= ay_in; cx_ff <= cx_in; cy_ff <= cy_in;
      rw_ff <= rw_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff; ovf_in = ovf_ff; drop_in = drop_ff;
      i_in = i_ff; n_in = n_ff; k_in = k_ff; sp_in = sp_ff;
      sidx_in = sidx_ff; sx_in = sx_ff; sy_in = sy_ff;
      px_in = px_ff; py_in = py_ff; pidx_in = pidx_ff;
      bx_in = bx_ff; by_in = by_ff; oidx_in = oidx_ff;
      m1_in = m1_ff; m2_in = m2_ff;
      ax_in = ax_ff; ay_in = ay_ff; cx_in = cx_ff; cy_in = cy_ff;
      rv_in = 1'b0; rw_in = rw_ff;
      pm_we = 1'b0; pm_addr = i_ff[IdxBits-1:0];
      pm_wdata = {req_word.point_x, req_word.point_y};
      om_we = 1'b0; om_addr = '0; om_wdata = oidx_ff;
      sm_we = 1'b0; sm_addr = '0; sm_wdata = pidx_ff;
      case (state_ff)
         // collect points
         ST_LOAD: begin
            pm_addr = count_ff[IdxBits-1:0];
            if (start) begin
               if (count_ff < CntBits'(MaxPoints)) begin
                  pm_we    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_word.set_last) begin
                  drop_in  = ovf_ff || (count_ff >= CntBits'(MaxPoints));
                  ovf_in   = 1'b0;
                  i_in     = '0;
                  sidx_in  = '0;
                  state_in = ST_MIN_RD;
               end
            end
         end
         // find lowest point
         ST_MIN_RD: begin
            state_in = ST_MIN_CMP;
         end
         ST_MIN_CMP: begin
            if (i_ff == '0 || ry < sy_ff || (ry == sy_ff && rx < sx_ff)) begin
               sidx_in = i_ff[IdxBits-1:0];
               sx_in = rx; sy_in = ry;
            end
            if (i_ff + 1'b1 == count_ff) begin
               i_in = '0; n_in = '0;
               state_in = ST_SRT_RDP;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_MIN_RD;
            end
         end
         // insertion sort: fetch point i
         ST_SRT_RDP: begin
            if (i_ff == count_ff) begin
               sp_in = '0; i_in = '0;
               state_in = ST_SCN_RDP;
            end else begin
               state_in = ST_SRT_WTP;
            end
         end
         ST_SRT_WTP: begin
            px_in = rx; py_in = ry; pidx_in = i_ff[IdxBits-1:0];
            ax_in = DiffBits'(rx) - DiffBits'(sx_ff);
            ay_in = DiffBits'(ry) - DiffBits'(sy_ff);
            k_in  = n_ff;
            if (rx == sx_ff && ry == sy_ff) begin
               i_in = i_ff + 1'b1;
               state_in = ST_SRT_RDP;
            end else begin
               state_in = ST_SRT_CHK;
            end
         end
         ST_SRT_CHK: begin
            if (k_ff == '0) begin
               om_addr = '0; om_we = 1'b1; om_wdata = pidx_ff;
               n_in = n_ff + 1'b1; i_in = i_ff + 1'b1;
               state_in = ST_SRT_RDP;
            end else begin
               om_addr  = IdxBits'(k_ff - 1'b1);
               state_in = ST_SRT_RDO;
            end
         end
         ST_SRT_RDO: begin
            oidx_in  = om_rdata;
            state_in = ST_SRT_WTO;
         end
         ST_SRT_WTO: begin
            pm_addr  = oidx_ff;
            state_in = ST_SRT_RDQ;
         end
         ST_SRT_RDQ: begin
            cx_in = DiffBits'(rx) - DiffBits'(sx_ff);
            cy_in = DiffBits'(ry) - DiffBits'(sy_ff);
            state_in = ST_SRT_WTQ;
         end
         ST_SRT_WTQ: begin
            m1_in = ax_ff * cy_ff;
            m2_in = ay_ff * cx_ff;
            state_in = ST_SRT_MUL;
         end
         ST_SRT_MUL: begin
            om_addr = IdxBits'(k_ff);
            if (before_w) begin
               om_we = 1'b1; om_wdata = oidx_ff;
               k_in = k_ff - 1'b1;
               state_in = ST_SRT_CHK;
            end else begin
               om_we = 1'b1; om_wdata = pidx_ff;
               n_in = n_ff + 1'b1; i_in = i_ff + 1'b1;
               state_in = ST_SRT_RDP;
            end
         end
         ST_SRT_DEC: begin
            state_in = ST_SRT_RDP;
         end
         // stack scan: push start, then each sorted point
         ST_SCN_RDP: begin
            if (sp_ff == '0) begin
               sm_addr = '0; sm_we = 1'b1; sm_wdata = sidx_ff;
               sp_in = CntBits'(1);
            end else if (i_ff == n_ff) begin
               i_in = '0;
               state_in = ST_OUT_RDI;
            end else begin
               om_addr  = IdxBits'(i_ff);
               state_in = ST_SCN_WTP;
            end
         end
         ST_SCN_WTP: begin
            pidx_in  = om_rdata;
            pm_addr  = om_rdata;
            state_in = ST_SCN_CHK;
         end
         // point p is on the read port here, both on entry and after a pop
         ST_SCN_CHK: begin
            px_in = rx; py_in = ry;
            if (sp_ff < CntBits'(2)) begin
               sm_addr = IdxBits'(sp_ff); sm_we = 1'b1;
               sp_in = sp_ff + 1'b1; i_in = i_ff + 1'b1;
               state_in = ST_SCN_RDP;
            end else begin
               sm_addr  = IdxBits'(sp_ff - 1'b1);
               state_in = ST_SCN_RDB;
            end
         end
         ST_SCN_RDB: begin
            pm_addr  = sm_rdata;
            sm_addr  = IdxBits'(sp_ff - CntBits'(2));
            state_in = ST_SCN_WTB;
         end
         ST_SCN_WTB: begin
            bx_in = rx; by_in = ry;
            pm_addr  = sm_rdata;
            state_in = ST_SCN_RDA;
         end
         ST_SCN_RDA: begin
            // a is in rx/ry, b in bx/by, p in px/py
            ax_in = DiffBits'(bx_ff) - DiffBits'(rx);
            ay_in = DiffBits'(by_ff) - DiffBits'(ry);
            cx_in = DiffBits'(px_ff) - DiffBits'(bx_ff);
            cy_in = DiffBits'(py_ff) - DiffBits'(by_ff);
            state_in = ST_SCN_WTA;
         end
         ST_SCN_WTA: begin
            m1_in = ax_ff * cy_ff;
            m2_in = ay_ff * cx_ff;
            state_in = ST_SCN_MUL;
         end
         ST_SCN_MUL: begin
            if (crs > 0) begin
               sm_addr = IdxBits'(sp_ff); sm_we = 1'b1;
               sp_in = sp_ff + 1'b1; i_in = i_ff + 1'b1;
               state_in = ST_SCN_RDP;
            end else begin
               sp_in = sp_ff - 1'b1;
               state_in = ST_SCN_DEC;
            end
         end
         // refetch point p for the next turn test
         ST_SCN_DEC: begin
            pm_addr  = pidx_ff;
            state_in = ST_SCN_CHK;
         end
         // emit hull from stack
         ST_OUT_RDI: begin
            sm_addr  = IdxBits'(i_ff);
            state_in = ST_OUT_WTI;
         end
         ST_OUT_WTI: begin
            pm_addr  = sm_rdata;
            state_in = ST_OUT_RDP;
         end
         ST_OUT_RDP: begin
            rv_in = 1'b1;
            rw_in.hull_x = rx;
            rw_in.hull_y = ry;
            rw_in.hull_last = (i_ff + 1'b1 == sp_ff);
            rw_in.dropped_points = drop_ff;
            state_in = ST_OUT_WTP;
         end
         ST_OUT_WTP: begin
            if (i_ff + 1'b1 == sp_ff) begin
               count_in = '0;
               state_in = ST_LOAD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_OUT_RDI;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule : convex_hull_graham_scan_unit
`default_nettype wire

/* bench/testbench.sv */
// self-checking bench for the convex hull unit: point sets in, hull vertices out
`default_nettype none
module testbench;
   import chgs_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   convex_hull_graham_scan_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: the point set collected so far
   longint       set_px[MaxPoints];
   longint       set_py[MaxPoints];
   int           set_count;
   bit           set_overflow;
   rsp_word_type hull_queue[$];
   req_word_type point_queue[$];
   int           idle_pct;
   int           mismatch_count;
   bit           saw_unexpected;

   // cross product of two difference vectors
   function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
      return ax * by - ay * bx;
   endfunction

   // true when point i sorts strictly ahead of point j around the start vertex
   function automatic bit angle_ahead(int i, int j, int s);
      longint ix, iy, jx, jy, d;
      ix = set_px[i] - set_px[s]; iy = set_py[i] - set_py[s];
      jx = set_px[j] - set_px[s]; jy = set_py[j] - set_py[s];
      d = cross2(ix, iy, jx, jy);
      if (d != 0) return d > 0;
      if ((ix < 0 ? -ix : ix) != (jx < 0 ? -jx : jx))
         return (ix < 0 ? -ix : ix) < (jx < 0 ? -jx : jx);
      return (iy < 0 ? -iy : iy) < (jy < 0 ? -jy : jy);
   endfunction

   // take one accepted word; on set close, queue the expected hull
   function automatic void predict_hull(req_word_type w);
      int order[MaxPoints];
      int stk[MaxPoints];
      int n, depth, s, k;
      longint ax, ay, bx, by;
      rsp_word_type r;
      n = 0; depth = 0; s = 0;
      if (set_count < MaxPoints) begin
         set_px[set_count] = w.point_x;
         set_py[set_count] = w.point_y;
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (!w.set_last) return;
      for (int i = 1; i < set_count; i++)
         if (set_py[i] < set_py[s] || (set_py[i] == set_py[s] && set_px[i] < set_px[s]))
            s = i;
      for (int i = 0; i < set_count; i++) begin
         if (set_px[i] == set_px[s] && set_py[i] == set_py[s]) continue;
         k = n;
         while (k > 0 && angle_ahead(i, order[k-1], s)) begin
            order[k] = order[k-1];
            k--;
         end
         order[k] = i;
         n++;
      end
      stk[depth++] = s;
      for (int i = 0; i < n; i++) begin
         while (depth >= 2) begin
            ax = set_px[stk[depth-1]] - set_px[stk[depth-2]];
            ay = set_py[stk[depth-1]] - set_py[stk[depth-2]];
            bx = set_px[order[i]] - set_px[stk[depth-1]];
            by = set_py[order[i]] - set_py[stk[depth-1]];
            if (cross2(ax, ay, bx, by) > 0) break;
            depth--;
         end
         if (depth < MaxPoints) stk[depth++] = order[i];
      end
      for (int i = 0; i < depth; i++) begin
         r.hull_x = CoordBits'(set_px[stk[i]]);
         r.hull_y = CoordBits'(set_py[stk[i]]);
         r.hull_last = (i == depth - 1);
         r.dropped_points = set_overflow;
         hull_queue = {hull_queue, r};
      end
      set_count = 0;
      set_overflow = 1'b0;
   endfunction

   // driver: present queued points, idling at random
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the word until taken
      end else begin
         if (start) begin
            predict_hull(req_word);
            void'(point_queue.pop_front());
         end
         if (point_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_word <= point_queue[0];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each vertex with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (hull_queue.size() == 0) begin
            saw_unexpected = 1'b1;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected vertex %p", rsp_word);
         end else begin
            if (rsp_word !== hull_queue[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("vertex mismatch: expected %p actual %p", hull_queue[0], rsp_word);
            end
            void'(hull_queue.pop_front());
         end
      end
   end

   // queue one point
   task automatic add_point(int x, int y, bit last);
      req_word_type w;
      w.point_x = CoordBits'(x); w.point_y = CoordBits'(y); w.set_last = last;
      point_queue = {point_queue, w};
   endtask

   // random set of n points: some sets in a narrow box, the rest across the full range
   task automatic add_random_set(int n);
      int span;
      span = ($urandom_range(3) == 0) ? 8 : 32767;
      for (int i = 0; i < n; i++) begin
         if (span == 8)
            add_point($urandom_range(16) - 8, $urandom_range(16) - 8, i == n - 1);
         else
            add_point($signed(16'($urandom)), $signed(16'($urandom)), i == n - 1);
      end
   endtask

   task automatic drain_queues();
      wait (point_queue.size() == 0 && start == 1'b0);
      wait (hull_queue.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      start = 1'b0;
      req_word = '0;
      reset = 1'b1;
      set_count = 0;
      set_overflow = 1'b0;
      idle_pct = 0;
      mismatch_count = 0;
      saw_unexpected = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed sets: single point, all equal, collinear, extremes, triangle, duplicate pair
      add_point(5, -3, 1);
      add_point(7, 7, 0); add_point(7, 7, 0); add_point(7, 7, 1);
      add_point(0, 0, 0); add_point(2, 2, 0); add_point(1, 1, 0); add_point(3, 3, 1);
      add_point(-32768, -32768, 0); add_point(32767, -32768, 0);
      add_point(32767, 32767, 0); add_point(-32768, 32767, 0);
      add_point(0, -32768, 0); add_point(0, 0, 1);
      add_point(0, 0, 0); add_point(4, 0, 0); add_point(0, 4, 0);
      add_point(2, 2, 0); add_point(1, 1, 0); add_point(0, 0, 1);
      add_point(-1, 5, 0); add_point(-1, 5, 0); add_point(3, -2, 1);
      drain_queues();

      // capacity overflow, including a dropped final point
      for (int i = 0; i < 66; i++)
         add_point($urandom_range(200) - 100, $urandom_range(200) - 100, i == 65);
      drain_queues();

      // random sets across idle phases
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 1) ? 60 : (ph == 2 ? 6 : 0);
         for (int k = 0; k < 10; k++) begin
            int n;
            n = $urandom_range(10, 1);
            add_random_set(n);
         end
         drain_queues();
      end
      idle_pct = 0;
      add_random_set(64);
      drain_queues();

      if (mismatch_count == 0 && !saw_unexpected)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
hdl/chgs_pkg.sv
hdl/chgs_ram.sv
hdl/convex_hull_graham_scan_unit.sv
bench/testbench.sv
